// ===== design/rvex_pkg.sv =====
// shared types, codes and helpers for the rv32im execute block
// used by every module of the block except rvex_ram; depends on nothing

package rvex_pkg;

  localparam int REG_COUNT_DEF = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  localparam logic [1:0] TRAP_NONE   = 2'd0;
  localparam logic [1:0] TRAP_EBREAK = 2'd1;
  localparam logic [1:0] TRAP_BAD    = 2'd2;

  localparam logic [0:0] CMD_EXEC = 1'b0;
  localparam logic [0:0] CMD_LRET = 1'b1;

  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
  localparam logic [4:0]  REG_A0 = 5'd10;

  typedef enum logic [3:0] {
    CLS_ALU_IMM, CLS_ALU_REG, CLS_MULDIV, CLS_AUIPC, CLS_LUI, CLS_JAL,
    CLS_JALR, CLS_BRANCH, CLS_STORE, CLS_LOAD, CLS_EBREAK, CLS_BAD, CLS_LRET
  } cls_t;

  typedef enum logic [2:0] {
    B_IDLE, B_READ, B_MUL, B_MULR, B_DIV, B_DIVF, B_DONE
  } back_state_t;

  typedef struct packed {
    logic [0:0]  command;
    logic [31:0] instruction;
    logic [31:0] pc;
    logic [31:0] load_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [1:0]  mem_op;
    logic [31:0] mem_addr;
    logic [1:0]  mem_size;
    logic [31:0] store_data;
    logic        write_enable;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic [1:0]  trap;
    logic [31:0] trap_code;
  } out_item_t;

  typedef struct packed {
    cls_t        cls;
    logic [2:0]  f3;
    logic        alt;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [4:0]  rd;
    logic [31:0] imm;
    logic [31:0] pc;
    logic [31:0] load_data;
  } dec_t;

endpackage

// ===== design/rvex_ram.sv =====
// generic register-file memory: one write port, two registered read ports
// no dependencies

module rvex_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== design/rvex_front.sv =====
// front end: classifies an incoming item and extracts fields and immediates
// depends on rvex_pkg

module rvex_front (
  input  rvex_pkg::in_item_t item,
  output rvex_pkg::dec_t     dec
);

  logic [31:0] inst;
  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;

  assign inst  = item.instruction;
  assign op    = inst[6:0];
  assign f3    = inst[14:12];
  assign f7    = inst[31:25];
  assign imm_i = {{20{inst[31]}}, inst[31:20]};
  assign imm_s = {{20{inst[31]}}, inst[31:25], inst[11:7]};
  assign imm_b = {{19{inst[31]}}, inst[31], inst[7], inst[30:25], inst[11:8], 1'b0};
  assign imm_j = {{11{inst[31]}}, inst[31], inst[19:12], inst[20], inst[30:21], 1'b0};
  assign imm_u = {inst[31:12], 12'd0};

  always_comb begin
    dec.cls       = rvex_pkg::CLS_BAD;
    dec.f3        = f3;
    dec.alt       = 1'b0;
    dec.rs1       = inst[19:15];
    dec.rs2       = inst[24:20];
    dec.rd        = inst[11:7];
    dec.imm       = imm_i;
    dec.pc        = item.pc;
    dec.load_data = item.load_data;
    if (item.command == rvex_pkg::CMD_LRET) begin
      dec.cls = rvex_pkg::CLS_LRET;
    end else begin
      case (op)
        rvex_pkg::OP_IMM: begin
          dec.alt = inst[30] && (f3 == 3'd5);
          if (f3 == 3'd1 && f7 != 7'h00) dec.cls = rvex_pkg::CLS_BAD;
          else if (f3 == 3'd5 && f7 != 7'h00 && f7 != 7'h20) dec.cls = rvex_pkg::CLS_BAD;
          else dec.cls = rvex_pkg::CLS_ALU_IMM;
        end
        rvex_pkg::OP_REG: begin
          dec.alt = inst[30];
          if (f7 == 7'h01) dec.cls = rvex_pkg::CLS_MULDIV;
          else if (f7 == 7'h00) dec.cls = rvex_pkg::CLS_ALU_REG;
          else if (f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5)) dec.cls = rvex_pkg::CLS_ALU_REG;
          else dec.cls = rvex_pkg::CLS_BAD;
        end
        rvex_pkg::OP_AUIPC: begin
          dec.cls = rvex_pkg::CLS_AUIPC;
          dec.imm = imm_u;
        end
        rvex_pkg::OP_LUI: begin
          dec.cls = rvex_pkg::CLS_LUI;
          dec.imm = imm_u;
        end
        rvex_pkg::OP_JAL: begin
          dec.cls = rvex_pkg::CLS_JAL;
          dec.imm = imm_j;
        end
        rvex_pkg::OP_JALR: begin
          dec.cls = (f3 == 3'd0) ? rvex_pkg::CLS_JALR : rvex_pkg::CLS_BAD;
        end
        rvex_pkg::OP_BRANCH: begin
          dec.imm = imm_b;
          dec.cls = (f3 == 3'd2 || f3 == 3'd3) ? rvex_pkg::CLS_BAD : rvex_pkg::CLS_BRANCH;
        end
        rvex_pkg::OP_STORE: begin
          dec.imm = imm_s;
          dec.cls = (f3 > 3'd2) ? rvex_pkg::CLS_BAD : rvex_pkg::CLS_STORE;
        end
        rvex_pkg::OP_LOAD: begin
          dec.cls = (f3 == 3'd3 || f3 > 3'd5) ? rvex_pkg::CLS_BAD : rvex_pkg::CLS_LOAD;
        end
        rvex_pkg::OP_SYSTEM: begin
          // ebreak reports a0, so read it through the rs1 port
          if (inst == rvex_pkg::EBREAK_WORD) begin
            dec.cls = rvex_pkg::CLS_EBREAK;
            dec.rs1 = rvex_pkg::REG_A0;
          end else begin
            dec.cls = rvex_pkg::CLS_BAD;
          end
        end
        default: dec.cls = rvex_pkg::CLS_BAD;
      endcase
    end
  end

endmodule

// ===== design/rvex_queue.sv =====
// short queue of decoded items between front and back
// depends on rvex_pkg

module rvex_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rvex_pkg::dec_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output rvex_pkg::dec_t rdata
);

  localparam int PW = $clog2(rvex_pkg::QUEUE_DEPTH);

  rvex_pkg::dec_t slot [rvex_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0]   count;
  logic          do_push, do_pop;

  assign full    = (count == (PW+1)'(rvex_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= (wptr == PW'(rvex_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (do_pop) rptr <= (rptr == PW'(rvex_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot[wptr] <= wdata;
  end

endmodule

// ===== design/rvex_back.sv =====
// back end: register file, alu, multiplier, iterative divider, result register
// depends on rvex_pkg and rvex_ram

module rvex_back #(
  parameter int REG_COUNT = rvex_pkg::REG_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  rvex_pkg::dec_t      q_data,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output rvex_pkg::out_item_t result
);

  localparam int AW = $clog2(REG_COUNT);

  rvex_pkg::back_state_t state, state_next;
  rvex_pkg::dec_t        dec;
  rvex_pkg::out_item_t   res, calc, out_res;
  logic                  out_valid;
  logic                  load_pending;
  logic [4:0]            load_dest;
  logic [2:0]            load_kind;
  logic [REG_COUNT-1:0]  valid;
  logic                  ok_a, ok_b;
  logic [31:0]           rdata_a, rdata_b, a, b;
  logic                  we;
  logic [4:0]            rd_sel;
  logic                  rd_ok;

  // multiplier and divider state
  logic [31:0]        ma, mb;
  logic               ma_sgn, mb_sgn;
  logic signed [65:0] prod;
  logic [31:0] dq, dd;
  logic [32:0] drem;
  logic [4:0]  cnt;
  logic        neg_q, neg_r, is_rem;
  logic [32:0] sh_rem, diff;
  logic        div_special;
  logic [31:0] div_special_val;
  logic [31:0] lret_val;

  assign empty = !out_valid;
  // finished item is held here so the next item can run while it waits
  assign result = out_res;

  function automatic logic idx_ok(input logic [4:0] idx);
    return (idx != 5'd0) && (32'(idx) < REG_COUNT);
  endfunction

  assign q_pop = (state == rvex_pkg::B_IDLE) && !q_empty;
  assign we = (state == rvex_pkg::B_DONE) && (!out_valid || pop) && res.write_enable;

  rvex_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_regs (
    .clk     (clk),
    .we      (we),
    .waddr   (res.dest_index[AW-1:0]),
    .wdata   (res.dest_value),
    .raddr_a (q_data.rs1[AW-1:0]),
    .raddr_b (q_data.rs2[AW-1:0]),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign a = ok_a ? rdata_a : 32'd0;
  assign b = ok_b ? rdata_b : 32'd0;

  // destination of this item: load return uses the saved one
  assign rd_sel = (dec.cls == rvex_pkg::CLS_LRET) ? load_dest : dec.rd;
  assign rd_ok  = idx_ok(rd_sel);

  always_comb begin
    case (load_kind)
      3'd0:    lret_val = {{24{dec.load_data[7]}}, dec.load_data[7:0]};
      3'd1:    lret_val = {{16{dec.load_data[15]}}, dec.load_data[15:0]};
      3'd4:    lret_val = {24'd0, dec.load_data[7:0]};
      3'd5:    lret_val = {16'd0, dec.load_data[15:0]};
      default: lret_val = dec.load_data;
    endcase
  end

  // combinational part of the work, valid in B_READ
  always_comb begin
    logic [31:0] op2, v, sum;
    logic [4:0]  sh;
    logic        wr, take, lt_s, lt_u;
    op2  = (dec.cls == rvex_pkg::CLS_ALU_IMM) ? dec.imm : b;
    sh   = op2[4:0];
    lt_s = $signed(a) < $signed(op2);
    lt_u = a < op2;
    sum  = a + dec.imm;
    v    = 32'd0;
    wr   = 1'b0;
    take = 1'b0;
    calc = '0;
    calc.next_pc = dec.pc + 32'd4;
    case (dec.cls)
      rvex_pkg::CLS_ALU_IMM, rvex_pkg::CLS_ALU_REG: begin
        wr = 1'b1;
        case (dec.f3)
          3'd0: v = (dec.alt && dec.cls == rvex_pkg::CLS_ALU_REG) ? a - op2 : a + op2;
          3'd1: v = a << sh;
          3'd2: v = {31'd0, lt_s};
          3'd3: v = {31'd0, lt_u};
          3'd4: v = a ^ op2;
          3'd5: v = dec.alt ? 32'($signed(a) >>> sh) : a >> sh;
          3'd6: v = a | op2;
          default: v = a & op2;
        endcase
      end
      rvex_pkg::CLS_MULDIV: begin
        wr = 1'b1;
        // divide by zero and signed overflow finish without the loop
        if (dec.f3[2] && div_special) v = div_special_val;
      end
      rvex_pkg::CLS_AUIPC: begin
        wr = 1'b1;
        v  = dec.pc + dec.imm;
      end
      rvex_pkg::CLS_LUI: begin
        wr = 1'b1;
        v  = dec.imm;
      end
      rvex_pkg::CLS_JAL: begin
        wr = 1'b1;
        v  = dec.pc + 32'd4;
        calc.next_pc = dec.pc + dec.imm;
      end
      rvex_pkg::CLS_JALR: begin
        wr = 1'b1;
        v  = dec.pc + 32'd4;
        calc.next_pc = {sum[31:1], 1'b0};
      end
      rvex_pkg::CLS_BRANCH: begin
        case (dec.f3)
          3'd0:    take = (a == b);
          3'd1:    take = (a != b);
          3'd4:    take = $signed(a) < $signed(b);
          3'd5:    take = !($signed(a) < $signed(b));
          3'd6:    take = a < b;
          default: take = a >= b;
        endcase
        if (take) calc.next_pc = dec.pc + dec.imm;
      end
      rvex_pkg::CLS_STORE: begin
        calc.mem_op     = rvex_pkg::MEM_STORE;
        calc.mem_addr   = sum;
        calc.mem_size   = dec.f3[1:0];
        calc.store_data = b;
      end
      rvex_pkg::CLS_LOAD: begin
        calc.mem_op   = rvex_pkg::MEM_LOAD;
        calc.mem_addr = sum;
        calc.mem_size = dec.f3[1:0];
      end
      rvex_pkg::CLS_EBREAK: begin
        calc.next_pc   = dec.pc;
        calc.trap      = rvex_pkg::TRAP_EBREAK;
        calc.trap_code = a;
      end
      rvex_pkg::CLS_LRET: begin
        calc.next_pc = 32'd0;
        wr = load_pending;
        v  = lret_val;
      end
      default: begin
        calc.next_pc = dec.pc;
        calc.trap    = rvex_pkg::TRAP_BAD;
      end
    endcase
    if (wr && rd_ok) begin
      calc.write_enable = 1'b1;
      calc.dest_index   = rd_sel;
      calc.dest_value   = v;
    end
  end

  // divider helpers
  assign sh_rem = {drem[31:0], dq[31]};
  assign diff   = sh_rem - {1'b0, dd};

  always_comb begin
    div_special     = 1'b0;
    div_special_val = 32'd0;
    if (b == 32'd0) begin
      div_special     = 1'b1;
      div_special_val = dec.f3[1] ? a : 32'hffff_ffff;
    end else if (!dec.f3[0] && a == 32'h8000_0000 && b == 32'hffff_ffff) begin
      div_special     = 1'b1;
      div_special_val = dec.f3[1] ? 32'd0 : 32'h8000_0000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rvex_pkg::B_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      rvex_pkg::B_IDLE: if (!q_empty) state_next = rvex_pkg::B_READ;
      rvex_pkg::B_READ: begin
        if (dec.cls == rvex_pkg::CLS_MULDIV && !dec.f3[2]) state_next = rvex_pkg::B_MUL;
        else if (dec.cls == rvex_pkg::CLS_MULDIV && !div_special) state_next = rvex_pkg::B_DIV;
        else state_next = rvex_pkg::B_DONE;
      end
      rvex_pkg::B_MUL:  state_next = rvex_pkg::B_MULR;
      rvex_pkg::B_MULR: state_next = rvex_pkg::B_DONE;
      rvex_pkg::B_DIV:  if (cnt == 5'd31) state_next = rvex_pkg::B_DIVF;
      rvex_pkg::B_DIVF: state_next = rvex_pkg::B_DONE;
      rvex_pkg::B_DONE: if (!out_valid || pop) state_next = rvex_pkg::B_IDLE;
      default: state_next = rvex_pkg::B_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      load_pending <= 1'b0;
      load_dest    <= 5'd0;
      load_kind    <= 3'd0;
      valid        <= '0;
    end else begin
      if (state == rvex_pkg::B_DONE && (!out_valid || pop)) out_valid <= 1'b1;
      else if (pop && out_valid) out_valid <= 1'b0;
      if (we) valid[res.dest_index[AW-1:0]] <= 1'b1;
      if (state == rvex_pkg::B_READ) begin
        if (dec.cls == rvex_pkg::CLS_LOAD) begin
          load_pending <= 1'b1;
          load_dest    <= dec.rd;
          load_kind    <= dec.f3;
        end else if (dec.cls == rvex_pkg::CLS_LRET) begin
          load_pending <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      rvex_pkg::B_IDLE: begin
        dec  <= q_data;
        ok_a <= idx_ok(q_data.rs1) && valid[q_data.rs1[AW-1:0]];
        ok_b <= idx_ok(q_data.rs2) && valid[q_data.rs2[AW-1:0]];
      end
      rvex_pkg::B_READ: begin
        res    <= calc;
        ma     <= a;
        mb     <= b;
        ma_sgn <= (dec.f3[1:0] == 2'd1) || (dec.f3[1:0] == 2'd2);
        mb_sgn <= (dec.f3[1:0] == 2'd1);
        is_rem <= dec.f3[1];
        neg_q  <= !dec.f3[0] && (a[31] != b[31]);
        neg_r  <= !dec.f3[0] && a[31];
        dq     <= (!dec.f3[0] && a[31]) ? 32'd0 - a : a;
        dd     <= (!dec.f3[0] && b[31]) ? 32'd0 - b : b;
        drem   <= 33'd0;
        cnt    <= 5'd0;
      end
      rvex_pkg::B_MUL: begin
        prod <= $signed({ma_sgn & ma[31], ma}) * $signed({mb_sgn & mb[31], mb});
      end
      rvex_pkg::B_MULR: begin
        if (res.write_enable)
          res.dest_value <= (dec.f3[1:0] == 2'd0) ? prod[31:0] : prod[63:32];
      end
      rvex_pkg::B_DIV: begin
        cnt <= cnt + 5'd1;
        if (!diff[32]) begin
          drem <= diff;
          dq   <= {dq[30:0], 1'b1};
        end else begin
          drem <= sh_rem;
          dq   <= {dq[30:0], 1'b0};
        end
      end
      rvex_pkg::B_DIVF: begin
        if (res.write_enable) begin
          if (is_rem) res.dest_value <= neg_r ? 32'd0 - drem[31:0] : drem[31:0];
          else res.dest_value <= neg_q ? 32'd0 - dq : dq;
        end
      end
      rvex_pkg::B_DONE: begin
        if (!out_valid || pop) out_res <= res;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/rv32im_execute_step.sv =====
// rv32im execute step: front decode, decoded-item queue, execute back end
// alu, branch, memory and trap items pass B_READ and B_DONE; multiply adds
// B_MUL and B_MULR; divide and remainder add the B_DIV loop (one quotient
// bit per cycle, 32 iterations) and B_DIVF, skipped on zero divisor or overflow
// the back end works on one item at a time
// reset: sync active-high rst empties the queue and result register, clears the
// load tracking, and marks all registers invalid so they read zero until written

module rv32im_execute_step #(
  parameter int REG_COUNT = rvex_pkg::REG_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  rvex_pkg::in_item_t  item,
  output logic                empty,
  input  logic                pop,
  output rvex_pkg::out_item_t result
);

  rvex_pkg::dec_t dec, q_data;
  logic           q_empty, q_pop;

  rvex_front u_front (
    .item (item),
    .dec  (dec)
  );

  rvex_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (dec),
    .full  (full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_data)
  );

  rvex_back #(.REG_COUNT(REG_COUNT)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
